// File: sv/osd_pkg.sv
// Shared types, constants and the glyph ROM for the OSD text pixel generator.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package osd_pkg;

  localparam int DEF_MAX_CHARS = 32;
  localparam int DEF_MAX_SCALE = 8;

  localparam int GLYPH_ROWS = 16;
  localparam int GLYPH_COLS = 8;

  localparam int CFG_AW = 4;
  localparam int CFG_DW = 32;

  localparam logic [3:0]  SCALE_RESET      = 4'd1;
  localparam logic [4:0]  CHAR_COUNT_RESET = 5'd19;
  localparam logic [15:0] FG_COLOR_RESET   = 16'hFFFF;

  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_DASH  = 8'h2D;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_COLON = 8'h3A;

  typedef enum logic [1:0] {
    REG_SCALE      = 2'd0,
    REG_CHAR_COUNT = 2'd1,
    REG_FG_COLOR   = 2'd2
  } cfg_reg_t;

  // Raster position and line/frame flags of one pixel request.
  typedef struct packed {
    logic [3:0] row;
    logic [2:0] col;
    logic       line_end;
    logic       frame_end;
  } osd_beat_t;

  // One glyph row, bit 7 is the leftmost column. Unknown codes draw as a space.
  function automatic logic [7:0] glyph_row_bits(input logic [7:0] code,
                                                input logic [3:0] row);
    logic [127:0] g;
    logic [127:0] sh;
    case (code)
      CHAR_ZERO:        g = 128'h00003C66_66666666_66666666_663C0000;
      CHAR_ZERO + 8'd1: g = 128'h00001838_78181818_18181818_187E0000;
      CHAR_ZERO + 8'd2: g = 128'h00003C66_66060C18_30606060_607E0000;
      CHAR_ZERO + 8'd3: g = 128'h00003C66_06060C1C_0C060666_663C0000;
      CHAR_ZERO + 8'd4: g = 128'h00000C1C_3C4C4CCC_7E0C0C0C_0C0C0000;
      CHAR_ZERO + 8'd5: g = 128'h00007E60_60607C06_06060666_663C0000;
      CHAR_ZERO + 8'd6: g = 128'h00003C66_6060607C_66666666_663C0000;
      CHAR_ZERO + 8'd7: g = 128'h00007E66_060C0C18_18303030_30300000;
      CHAR_ZERO + 8'd8: g = 128'h00003C66_66663C66_66666666_663C0000;
      CHAR_ZERO + 8'd9: g = 128'h00003C66_6666663E_06060666_663C0000;
      CHAR_DASH:        g = 128'h00000000_0000003C_3C000000_00000000;
      CHAR_COLON:       g = 128'h00000000_00181800_00181800_00000000;
      default:          g = '0;
    endcase
    // Row 0 sits in the top byte; shift the wanted row down to the bottom.
    sh = g >> {~row, 3'b000};
    return sh[7:0];
  endfunction

endpackage

`default_nettype wire

// File: sv/osd_cfg.sv
// APB-style configuration registers: scale, char_count and fg_color.
// Depends on osd_pkg for register indexes, widths and reset values.
`default_nettype none

module osd_cfg (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [osd_pkg::CFG_AW-1:0] paddr,
  input  wire logic [osd_pkg::CFG_DW-1:0] pwdata,
  output logic      [osd_pkg::CFG_DW-1:0] prdata,
  output logic                            pready,
  output logic      [3:0]                 scale,
  output logic      [4:0]                 char_count,
  output logic      [15:0]                fg_color
);
  import osd_pkg::*;

  cfg_reg_t reg_sel;
  logic     wr_en;

  assign pready  = 1'b1;
  assign reg_sel = cfg_reg_t'(paddr[CFG_AW-1:2]);
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      scale      <= SCALE_RESET;
      char_count <= CHAR_COUNT_RESET;
      fg_color   <= FG_COLOR_RESET;
    end else if (wr_en) begin
      case (reg_sel)
        REG_SCALE:      scale      <= pwdata[3:0];
        REG_CHAR_COUNT: char_count <= pwdata[4:0];
        REG_FG_COLOR:   fg_color   <= pwdata[15:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_SCALE:      prdata = CFG_DW'(scale);
      REG_CHAR_COUNT: prdata = CFG_DW'(char_count);
      REG_FG_COLOR:   prdata = CFG_DW'(fg_color);
      default:        prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

// File: sv/osd_text_mem.sv
// Text store: synchronous memory with one write and one registered read port.
// Per-entry valid bits make unwritten entries read as a space after reset.
`default_nettype none

module osd_text_mem #(
  parameter int MAX_CHARS = osd_pkg::DEF_MAX_CHARS
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       wr_en,
  input  wire logic [4:0] wr_index,
  input  wire logic [7:0] wr_code,
  input  wire logic       rd_en,
  input  wire logic [4:0] rd_index,
  output logic      [7:0] rd_code
);
  import osd_pkg::*;

  localparam int AW = $clog2(MAX_CHARS);

  logic [7:0]           mem [MAX_CHARS];
  logic [MAX_CHARS-1:0] written;
  logic [7:0]           rd_data;
  logic                 rd_hit;
  logic                 wr_ok;
  logic                 rd_ok;
  logic [AW-1:0]        wr_addr;
  logic [AW-1:0]        rd_addr;

  assign wr_ok   = 32'(wr_index) < MAX_CHARS;
  assign rd_ok   = 32'(rd_index) < MAX_CHARS;
  assign wr_addr = AW'(wr_index);
  assign rd_addr = AW'(rd_index);

  // At most one request enters per cycle, so a read and a write never share an edge
  // and the read always sees every earlier write.
  always_ff @(posedge clk) begin
    if (wr_en && wr_ok) begin
      mem[wr_addr] <= wr_code;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      written <= '0;
    end else if (wr_en && wr_ok) begin
      written[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_hit <= rd_ok && written[rd_addr];
    end
  end

  assign rd_code = rd_hit ? rd_data : CHAR_SPACE;

endmodule

`default_nettype wire

// File: sv/osd_raster.sv
// Raster counters: repeat, column, character, row repeat and glyph row.
// Depends on osd_pkg for the beat struct and glyph dimensions.
`default_nettype none

module osd_raster #(
  parameter int MAX_CHARS = osd_pkg::DEF_MAX_CHARS,
  parameter int MAX_SCALE = osd_pkg::DEF_MAX_SCALE
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  step,
  input  wire logic [3:0]            scale,
  input  wire logic [4:0]            char_count,
  output logic      [4:0]            position,
  output osd_pkg::osd_beat_t         beat
);
  import osd_pkg::*;

  localparam int RW = (MAX_SCALE > 1) ? $clog2(MAX_SCALE) : 1;
  localparam int SW = $clog2(MAX_SCALE + 1);

  logic [RW-1:0] col_rep;
  logic [RW-1:0] row_rep;
  logic [2:0]    col;
  logic [3:0]    row;
  logic [SW-1:0] scale_eff;
  logic [4:0]    count_eff;
  logic          col_rep_last;
  logic          col_last;
  logic          char_last;
  logic          row_rep_last;
  logic          row_last;

  always_comb begin
    if (scale == 4'd0) begin
      scale_eff = SW'(1);
    end else if (32'(scale) > MAX_SCALE) begin
      scale_eff = SW'(MAX_SCALE);
    end else begin
      scale_eff = SW'(scale);
    end
    if (char_count == 5'd0) begin
      count_eff = 5'd1;
    end else if (32'(char_count) > MAX_CHARS) begin
      count_eff = 5'(MAX_CHARS);
    end else begin
      count_eff = char_count;
    end
  end

  // A counter at or past its limit counts as being on its last step.
  assign col_rep_last = (32'(col_rep) + 32'd1) >= 32'(scale_eff);
  assign row_rep_last = (32'(row_rep) + 32'd1) >= 32'(scale_eff);
  assign col_last     = 32'(col) == GLYPH_COLS - 1;
  assign row_last     = 32'(row) == GLYPH_ROWS - 1;
  assign char_last    = (32'(position) + 32'd1) >= 32'(count_eff);

  assign beat.row       = row;
  assign beat.col       = col;
  assign beat.line_end  = col_rep_last && col_last && char_last;
  assign beat.frame_end = beat.line_end && row_rep_last && row_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      col_rep  <= '0;
      col      <= '0;
      position <= '0;
      row_rep  <= '0;
      row      <= '0;
    end else if (step) begin
      if (!col_rep_last) begin
        col_rep <= col_rep + RW'(1);
      end else begin
        col_rep <= '0;
        if (!col_last) begin
          col <= col + 3'd1;
        end else begin
          col <= '0;
          if (!char_last) begin
            position <= position + 5'd1;
          end else begin
            position <= '0;
            if (!row_rep_last) begin
              row_rep <= row_rep + RW'(1);
            end else begin
              row_rep <= '0;
              row     <= row + 4'd1;
            end
          end
        end
      end
    end
  end

endmodule

`default_nettype wire

// File: sv/osd_text_pixel_generator.sv
// OSD text pixel generator: text store plus raster counters and glyph ROM.
// Path: a pixel request's store read and raster beat are registered in stage 1,
// then the pixel enters the output register once that is free (out_ready).
// Throughput: one request per cycle while in_ready is high, write or pixel; the
// registered text store read and the output register form the two stages.
// Reset: synchronous; counters clear, registers take their defaults and the
// store's valid bits clear at once so it reads as spaces (no clearing pass).
`default_nettype none

module osd_text_pixel_generator #(
  parameter int MAX_CHARS = osd_pkg::DEF_MAX_CHARS,
  parameter int MAX_SCALE = osd_pkg::DEF_MAX_SCALE
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [osd_pkg::CFG_AW-1:0] paddr,
  input  wire logic [osd_pkg::CFG_DW-1:0] pwdata,
  output logic      [osd_pkg::CFG_DW-1:0] prdata,
  output logic                            pready,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic                       opcode,
  input  wire logic [4:0]                 char_index,
  input  wire logic [7:0]                 char_code,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic      [15:0]                pixel,
  output logic                            line_end,
  output logic                            frame_end
);
  import osd_pkg::*;

  logic [3:0]  scale;
  logic [4:0]  char_count;
  logic [15:0] fg_color;
  logic [4:0]  position;
  osd_beat_t   beat;
  osd_beat_t   s1_beat;
  logic        s1_valid;
  logic [7:0]  rd_code;
  logic [7:0]  row_bits;
  logic        lit;
  logic        out_load;
  logic        pix_accept;
  logic        wr_accept;

  osd_cfg u_cfg (
    .clk        (clk),
    .rst        (rst),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .scale      (scale),
    .char_count (char_count),
    .fg_color   (fg_color)
  );

  assign out_load   = s1_valid && (!out_valid || out_ready);
  assign in_ready   = !s1_valid || out_load;
  assign pix_accept = in_valid && in_ready && opcode;
  assign wr_accept  = in_valid && in_ready && !opcode;

  osd_raster #(
    .MAX_CHARS (MAX_CHARS),
    .MAX_SCALE (MAX_SCALE)
  ) u_raster (
    .clk        (clk),
    .rst        (rst),
    .step       (pix_accept),
    .scale      (scale),
    .char_count (char_count),
    .position   (position),
    .beat       (beat)
  );

  osd_text_mem #(
    .MAX_CHARS (MAX_CHARS)
  ) u_mem (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_accept),
    .wr_index (char_index),
    .wr_code  (char_code),
    .rd_en    (pix_accept),
    .rd_index (position),
    .rd_code  (rd_code)
  );

  // Stage 1 holds the raster beat alongside the store read in flight.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (pix_accept) begin
      s1_valid <= 1'b1;
    end else if (out_load) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pix_accept) begin
      s1_beat <= beat;
    end
  end

  assign row_bits = glyph_row_bits(rd_code, s1_beat.row);
  assign lit      = row_bits[~s1_beat.col];

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      pixel     <= lit ? fg_color : 16'h0000;
      line_end  <= s1_beat.line_end;
      frame_end <= s1_beat.frame_end;
    end
  end

  a_frame_has_line_end: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (!frame_end || line_end))
    else $error("frame_end without line_end");

  a_pixel_fills_stage: assert property (@(posedge clk) disable iff (rst)
    pix_accept |=> s1_valid)
    else $error("pixel request did not enter the read stage");

  a_write_no_result: assert property (@(posedge clk) disable iff (rst)
    wr_accept |=> !s1_valid)
    else $error("write request produced a pixel");

  a_unlit_is_zero: assert property (@(posedge clk) disable iff (rst)
    (out_load && !lit) |=> (pixel == 16'h0000))
    else $error("unlit dot gave a nonzero pixel");

endmodule

`default_nettype wire

// File: tb/sv/osd_tb_pkg.sv
// Request codes shared by the OSD text pixel generator testbench files.
// No dependencies; imported by the checker and the testbench top.
package osd_tb_pkg;

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_PIXEL = 1'b1
  } osd_op_t;

endpackage

// File: tb/sv/osd_pixel_checker.sv
// Checker for the OSD text pixel generator: follows register writes and requests,
// renders the expected pixel stream and compares it with the block's output.
// Depends on osd_pkg (register codes, character codes) and osd_tb_pkg.
module osd_pixel_checker (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [osd_pkg::CFG_AW-1:0] paddr,
  input  logic [osd_pkg::CFG_DW-1:0] pwdata,
  input  logic                       pready,
  input  logic                       in_valid,
  input  logic                       in_ready,
  input  logic                       opcode,
  input  logic [4:0]                 char_index,
  input  logic [7:0]                 char_code,
  input  logic                       out_valid,
  input  logic                       out_ready,
  input  logic [15:0]                pixel,
  input  logic                       line_end,
  input  logic                       frame_end,
  output int                         mismatches,
  output int                         outstanding
);
  import osd_pkg::*;
  import osd_tb_pkg::*;

  localparam int SLOT_DASH  = 10;
  localparam int SLOT_COLON = 11;
  localparam int SLOT_BLANK = 12;

  // Digits 0..9, dash, colon, blank; row 0 is the top byte.
  localparam logic [0:12][127:0] GLYPH_ROM = {
    128'h00003C66_66666666_66666666_663C0000,
    128'h00001838_78181818_18181818_187E0000,
    128'h00003C66_66060C18_30606060_607E0000,
    128'h00003C66_06060C1C_0C060666_663C0000,
    128'h00000C1C_3C4C4CCC_7E0C0C0C_0C0C0000,
    128'h00007E60_60607C06_06060666_663C0000,
    128'h00003C66_6060607C_66666666_663C0000,
    128'h00007E66_060C0C18_18303030_30300000,
    128'h00003C66_66663C66_66666666_663C0000,
    128'h00003C66_6666663E_06060666_663C0000,
    128'h00000000_0000003C_3C000000_00000000,
    128'h00000000_00181800_00181800_00000000,
    128'h00000000_00000000_00000000_00000000
  };

  typedef struct packed {
    logic [15:0] pixel;
    logic        line_end;
    logic        frame_end;
  } pix_t;

  pix_t expected_pixels[$];
  pix_t want;
  pix_t rendered;
  int   err_count = 0;

  logic [7:0]  text_mem [DEF_MAX_CHARS];
  logic [3:0]  scale_reg;
  logic [4:0]  count_reg;
  logic [15:0] fg_reg;
  logic [4:0]  char_pos;
  logic [2:0]  dot_col;
  logic [2:0]  col_rep;
  logic [3:0]  dot_row;
  logic [2:0]  row_rep;

  function automatic logic [7:0] glyph_row_byte(input logic [7:0] code,
                                                input logic [3:0] row);
    int           slot;
    logic [127:0] bits;
    if (code >= CHAR_ZERO && code <= CHAR_ZERO + 8'd9) begin
      slot = int'(code - CHAR_ZERO);
    end else if (code == CHAR_DASH) begin
      slot = SLOT_DASH;
    end else if (code == CHAR_COLON) begin
      slot = SLOT_COLON;
    end else begin
      slot = SLOT_BLANK;
    end
    bits = GLYPH_ROM[slot];
    return bits[127 - 8 * int'(row) -: 8];
  endfunction

  // Renders the pixel under the raster position and advances the raster.
  task automatic render_pixel(output pix_t res);
    int         s;
    int         n;
    logic [7:0] code;
    logic [7:0] row_bits;
    logic       col_rep_last;
    logic       col_last;
    logic       char_last;
    logic       row_rep_last;
    logic       row_last;
    s = (scale_reg == 0) ? 1 : int'(scale_reg);
    if (s > DEF_MAX_SCALE) s = DEF_MAX_SCALE;
    n = (count_reg == 0) ? 1 : int'(count_reg);
    if (n > DEF_MAX_CHARS) n = DEF_MAX_CHARS;
    code = (int'(char_pos) < DEF_MAX_CHARS) ? text_mem[char_pos] : CHAR_SPACE;
    row_bits = glyph_row_byte(code, dot_row);
    res.pixel = row_bits[3'd7 - dot_col] ? fg_reg : 16'h0000;

    // A counter at or past a freshly lowered limit counts as on its last step.
    col_rep_last = int'(col_rep) + 1 >= s;
    col_last     = int'(dot_col) + 1 >= GLYPH_COLS;
    char_last    = int'(char_pos) + 1 >= n;
    row_rep_last = int'(row_rep) + 1 >= s;
    row_last     = int'(dot_row) + 1 >= GLYPH_ROWS;
    res.line_end  = col_rep_last && col_last && char_last;
    res.frame_end = res.line_end && row_rep_last && row_last;

    if (!col_rep_last) begin
      col_rep = col_rep + 3'd1;
    end else begin
      col_rep = '0;
      if (!col_last) begin
        dot_col = dot_col + 3'd1;
      end else begin
        dot_col = '0;
        if (!char_last) begin
          char_pos = char_pos + 5'd1;
        end else begin
          char_pos = '0;
          if (!row_rep_last) begin
            row_rep = row_rep + 3'd1;
          end else begin
            row_rep = '0;
            dot_row = row_last ? 4'd0 : dot_row + 4'd1;
          end
        end
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < DEF_MAX_CHARS; i++) text_mem[i] = CHAR_SPACE;
      scale_reg = SCALE_RESET;
      count_reg = CHAR_COUNT_RESET;
      fg_reg    = FG_COLOR_RESET;
      char_pos  = '0;
      dot_col   = '0;
      col_rep   = '0;
      dot_row   = '0;
      row_rep   = '0;
      expected_pixels.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (cfg_reg_t'(paddr[3:2]))
          REG_SCALE:      scale_reg = pwdata[3:0];
          REG_CHAR_COUNT: count_reg = pwdata[4:0];
          REG_FG_COLOR:   fg_reg    = pwdata[15:0];
          default: ;
        endcase
      end

      if (out_valid && out_ready) begin
        if (expected_pixels.size() == 0) begin
          err_count++;
          $display("%0t: unexpected pixel: expected none, got pixel %h line_end %b frame_end %b",
                   $time, pixel, line_end, frame_end);
        end else begin
          want = expected_pixels.pop_front();
          if (pixel !== want.pixel) begin
            err_count++;
            $display("%0t: pixel mismatch: expected %h, got %h", $time, want.pixel, pixel);
          end
          if (line_end !== want.line_end) begin
            err_count++;
            $display("%0t: line_end mismatch: expected %b, got %b",
                     $time, want.line_end, line_end);
          end
          if (frame_end !== want.frame_end) begin
            err_count++;
            $display("%0t: frame_end mismatch: expected %b, got %b",
                     $time, want.frame_end, frame_end);
          end
        end
      end

      if (in_valid && in_ready) begin
        if (opcode == OP_PIXEL) begin
          render_pixel(rendered);
          expected_pixels.push_back(rendered);
        end else begin
          text_mem[char_index] = char_code;
        end
      end
    end
    outstanding <= expected_pixels.size();
    mismatches  <= err_count;
  end

endmodule

// File: tb/sv/osd_text_pixel_generator_tb.sv
// Testbench top for the OSD text pixel generator: clock, reset, register writes
// and request stimulus with random stalls on both sides; the verdict comes from
// osd_pixel_checker. Depends on osd_pkg, osd_tb_pkg and the block itself.
module osd_text_pixel_generator_tb;
  import osd_pkg::*;
  import osd_tb_pkg::*;

  localparam int         SINK_HOLD_CYCLES = 300;
  localparam int         DRAIN_CYCLES     = 4;
  localparam logic [7:0] CHAR_HASH        = 8'h23;

  logic                clk;
  logic                rst        = 1'b1;
  logic                psel       = 1'b0;
  logic                penable    = 1'b0;
  logic                pwrite     = 1'b0;
  logic [CFG_AW-1:0]   paddr      = '0;
  logic [CFG_DW-1:0]   pwdata     = '0;
  logic [CFG_DW-1:0]   prdata;
  logic                pready;
  logic                in_valid   = 1'b0;
  logic                in_ready;
  logic                opcode     = 1'b0;
  logic [4:0]          char_index = '0;
  logic [7:0]          char_code  = '0;
  logic                out_valid;
  logic                out_ready  = 1'b0;
  logic [15:0]         pixel;
  logic                line_end;
  logic                frame_end;
  int                  mismatches;
  int                  outstanding;

  int src_idle_pct  = 25;
  int sink_idle_pct = 25;
  int hold_asks     = 0;
  int hold_done     = 0;

  osd_text_pixel_generator uut (
    .clk        (clk),
    .rst        (rst),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .opcode     (opcode),
    .char_index (char_index),
    .char_code  (char_code),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .pixel      (pixel),
    .line_end   (line_end),
    .frame_end  (frame_end)
  );

  osd_pixel_checker checker_i (
    .clk         (clk),
    .rst         (rst),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .pready      (pready),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .opcode      (opcode),
    .char_index  (char_index),
    .char_code   (char_code),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .pixel       (pixel),
    .line_end    (line_end),
    .frame_end   (frame_end),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("== FAIL ==");
    $finish;
  end

  // Receiver: random stalls, plus a long hold-off whenever one is asked for.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_asks != hold_done) begin
        out_ready <= 1'b0;
        repeat (SINK_HOLD_CYCLES) @(posedge clk);
        hold_done = hold_asks;
      end else begin
        out_ready <= ($urandom_range(99) >= sink_idle_pct);
      end
    end
  end

  task automatic send_item(input osd_op_t op, input logic [4:0] idx, input logic [7:0] code);
    int gap;
    gap = 0;
    if ($urandom_range(99) < src_idle_pct) gap = $urandom_range(2, 1);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    opcode     <= op;
    char_index <= idx;
    char_code  <= code;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Let every pixel request finish before touching the registers.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t r, input logic [CFG_DW-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {r, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // Upper data bits are random; the block keeps only the register's width.
  task automatic set_config(input logic [3:0] s, input logic [4:0] n, input logic [15:0] fg);
    write_reg(REG_SCALE, {28'($urandom), s});
    write_reg(REG_CHAR_COUNT, {27'($urandom), n});
    write_reg(REG_FG_COLOR, {16'($urandom), fg});
  endtask

  function automatic logic [7:0] pick_code();
    logic [7:0] c;
    case ($urandom_range(9))
      0, 1, 2: c = 8'($urandom_range(255));
      3:       c = CHAR_DASH;
      4:       c = CHAR_COLON;
      5:       c = CHAR_SPACE;
      default: c = CHAR_ZERO + 8'($urandom_range(9));
    endcase
    return c;
  endfunction

  // Mostly pixel requests; writes land mostly on the characters being drawn.
  task automatic run_mix(input int items, input int shown);
    logic [4:0] idx;
    repeat (items) begin
      if ($urandom_range(99) < 85) begin
        send_item(OP_PIXEL, 5'($urandom), 8'($urandom));
      end else begin
        if ($urandom_range(99) < 70) idx = 5'($urandom_range(shown - 1));
        else idx = 5'($urandom_range(31));
        send_item(OP_WRITE, idx, pick_code());
      end
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Fresh store reads as spaces under the reset register values.
    repeat (6) send_item(OP_PIXEL, 5'd0, 8'd0);
    for (int k = 0; k < 10; k++) send_item(OP_WRITE, 5'(k + 4), CHAR_ZERO + 8'(k));
    send_item(OP_WRITE, 5'd0, CHAR_DASH);
    send_item(OP_WRITE, 5'd1, CHAR_COLON);
    send_item(OP_WRITE, 5'd2, CHAR_HASH);
    send_item(OP_WRITE, 5'd3, CHAR_SPACE);
    send_item(OP_WRITE, 5'd31, 8'hFF);
    send_item(OP_WRITE, 5'd30, 8'h00);
    repeat (4) send_item(OP_PIXEL, 5'd31, 8'hFF);

    settle();
    set_config(4'd1, 5'd1, 16'hFFFF);
    send_item(OP_WRITE, 5'd0, CHAR_ZERO + 8'd8);
    run_mix(100, 1);
    // Long output stall while requests keep coming, so the block backs up.
    hold_asks++;
    run_mix(200, 1);

    settle();
    set_config(4'd0, 5'd0, 16'h0000);
    run_mix(150, 1);

    settle();
    set_config(4'd15, 5'd31, 16'h8001);
    run_mix(120, 31);

    // Shrinking the strip mid-frame forces the raster to wrap early.
    settle();
    set_config(4'd1, 5'd2, 16'($urandom));
    src_idle_pct  = 0;
    sink_idle_pct = 0;
    run_mix(200, 2);
    src_idle_pct  = 25;
    sink_idle_pct = 25;
    run_mix(150, 2);

    settle();
    set_config(4'd2, 5'd1, 16'($urandom));
    run_mix(150, 1);
    settle();
    run_mix(150, 1);

    settle();
    set_config(4'd8, 5'd1, 16'h7FFF);
    run_mix(150, 1);

    settle();
    set_config(4'd1, 5'd3, 16'($urandom));
    run_mix(80, 3);

    settle();
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
